// ----- rtl/core/box_blur_3x3_rgb_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Box blur assertion macros
// Concurrent check macros for the box blur unit, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`ifndef SYNTH
// The antecedent and the consequent hold in the same cycle.
`define BB3_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur check failed");
// The consequent holds in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur check failed");
`else
`define BB3_ASSERT_IMPLIES(name, ante, cons)
`define BB3_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/core/bb3_pkg.sv -----
// ----------------------------------------------------------------------------
// Box blur package
// Shared constants, types and register indexes of the 3x3 box blur unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

    localparam int LINE_DEPTH   = 1024;
    localparam int COL_W        = $clog2(LINE_DEPTH);
    localparam int MAX_LINES    = 4096;
    localparam int ROW_W        = $clog2(MAX_LINES);
    localparam int CHAN_W       = 8;
    localparam int COLSUM_W     = 10;
    localparam int WINSUM_W     = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam int RECIP_W      = 13;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_W       = WINSUM_W + RECIP_W;

    typedef logic [COL_W-1:0]        col_t;
    typedef logic [ROW_W-1:0]        row_t;
    typedef logic [WIDTH_REG_W-1:0]  width_t;
    typedef logic [HEIGHT_REG_W-1:0] height_t;
    typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;
    typedef logic [COLSUM_W-1:0]     colval_t;
    typedef logic [WINSUM_W-1:0]     winval_t;
    typedef logic [PROD_W-1:0]       prod_t;

    localparam width_t  WIDTH_MIN    = WIDTH_REG_W'(3);
    localparam width_t  WIDTH_MAX    = WIDTH_REG_W'(LINE_DEPTH);
    localparam width_t  WIDTH_RESET  = WIDTH_REG_W'(800);
    localparam height_t HEIGHT_MIN   = HEIGHT_REG_W'(3);
    localparam height_t HEIGHT_MAX   = HEIGHT_REG_W'(MAX_LINES);
    localparam height_t HEIGHT_RESET = HEIGHT_REG_W'(600);

    // Reciprocal of nine scaled by 2^16; exact for window sums below 2296.
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

    localparam cfg_index_t REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam cfg_index_t REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    // One column of both line stores, kept together at the same address.
    typedef struct packed {
        rgb_t older;
        rgb_t newer;
    } line_pair_t;

    localparam int LINE_PAIR_W = $bits(line_pair_t);

    typedef struct packed {
        rgb_t top;
        rgb_t mid;
        rgb_t bot;
    } column_t;

    typedef struct packed {
        colval_t r;
        colval_t g;
        colval_t b;
    } colsum_t;

    typedef struct packed {
        winval_t r;
        winval_t g;
        winval_t b;
    } winsum_t;

    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctl_t;

    typedef struct packed {
        logic has0;
        logic has1;
        col_t x0;
        col_t x1;
        row_t y;
        logic last0;
        logic eof;
    } result_meta_t;

    typedef struct packed {
        logic         okl;
        logic         okm;
        logic         okr;
        result_meta_t meta;
    } win_info_t;

    typedef struct packed {
        logic      flush;
        logic      first;
        logic      clr;
        logic      mask1;
        logic      mask2;
        col_t      addr;
        rgb_t      rgb;
        win_info_t info;
    } fetch_t;

endpackage

`default_nettype wire

// ----- rtl/core/bb3_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bb3_cell.sv -----
// ----------------------------------------------------------------------------
// Box blur window cell
// Holds one column of the 3x3 window and gives its per-channel column sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bb3_pkg::cell_ctl_t ctl,
    input  wire bb3_pkg::column_t   din,
    output bb3_pkg::column_t        q,
    output bb3_pkg::colsum_t        colsum
);

    bb3_pkg::column_t col_reg;
    bb3_pkg::column_t col_next;

    always_comb
    begin
        col_next = col_reg;
        if (ctl.shift)
        begin
            col_next = ctl.clr ? '0 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign q = col_reg;

    always_comb
    begin
        colsum.r = bb3_pkg::colval_t'(col_reg.top.r) + bb3_pkg::colval_t'(col_reg.mid.r)
                 + bb3_pkg::colval_t'(col_reg.bot.r);
        colsum.g = bb3_pkg::colval_t'(col_reg.top.g) + bb3_pkg::colval_t'(col_reg.mid.g)
                 + bb3_pkg::colval_t'(col_reg.bot.g);
        colsum.b = bb3_pkg::colval_t'(col_reg.top.b) + bb3_pkg::colval_t'(col_reg.mid.b)
                 + bb3_pkg::colval_t'(col_reg.bot.b);
    end

endmodule

`default_nettype wire

// ----- rtl/core/bb3_div9.sv -----
// ----------------------------------------------------------------------------
// Divide by nine
// Truncating division of three window sums by nine through a reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_div9 (
    input  wire bb3_pkg::winsum_t sum,
    output bb3_pkg::rgb_t         quot
);

    bb3_pkg::prod_t prod_r;
    bb3_pkg::prod_t prod_g;
    bb3_pkg::prod_t prod_b;

    assign prod_r = bb3_pkg::prod_t'(sum.r) * bb3_pkg::prod_t'(bb3_pkg::RECIP_9);
    assign prod_g = bb3_pkg::prod_t'(sum.g) * bb3_pkg::prod_t'(bb3_pkg::RECIP_9);
    assign prod_b = bb3_pkg::prod_t'(sum.b) * bb3_pkg::prod_t'(bb3_pkg::RECIP_9);

    assign quot.r = prod_r[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    assign quot.g = prod_g[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    assign quot.b = prod_b[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];

endmodule

`default_nettype wire

// ----- rtl/core/box_blur_3x3_rgb_unit.sv -----
// Path: fetch, window and sum stages, then the output register, before a result is valid.
// Throughput: one input word per cycle while nothing stalls, set by the single-read line
// store RAM and three-cell window chain; a last-column pixel shows two results in turn.
// Reset: counters, drain flag and window cells clear at once; the line store RAM is
// not cleared, since stale data read before an entry is written is masked to zero.
// ----------------------------------------------------------------------------
// 3x3 box blur unit
// Streaming RGB box filter with two line stores and a three-cell window chain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_blur_3x3_rgb_unit_assert.svh"

module box_blur_3x3_rgb_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bb3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [bb3_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                pixel_valid,
    output logic                                     pixel_stall,
    input  wire logic                                action,
    input  wire logic [31:0]                         pixel_word,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [31:0]                              out_pixel,
    output logic [bb3_pkg::COL_W-1:0]                out_x,
    output logic [bb3_pkg::ROW_W-1:0]                out_y,
    output logic                                     out_last,
    output logic                                     end_of_frame
);

    // Configuration
    bb3_pkg::width_t  frame_width_reg;
    bb3_pkg::height_t frame_height_reg;
    bb3_pkg::width_t  eff_w;
    bb3_pkg::width_t  eff_wm1;
    bb3_pkg::height_t eff_h;
    bb3_pkg::height_t eff_hm1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bb3_pkg::WIDTH_RESET;
            frame_height_reg <= bb3_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bb3_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_wdata[bb3_pkg::WIDTH_REG_W-1:0];
                end
                bb3_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_wdata[bb3_pkg::HEIGHT_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg < bb3_pkg::WIDTH_MIN)
        begin
            eff_w = bb3_pkg::WIDTH_MIN;
        end
        else if (frame_width_reg > bb3_pkg::WIDTH_MAX)
        begin
            eff_w = bb3_pkg::WIDTH_MAX;
        end
        else
        begin
            eff_w = frame_width_reg;
        end
        if (frame_height_reg < bb3_pkg::HEIGHT_MIN)
        begin
            eff_h = bb3_pkg::HEIGHT_MIN;
        end
        else if (frame_height_reg > bb3_pkg::HEIGHT_MAX)
        begin
            eff_h = bb3_pkg::HEIGHT_MAX;
        end
        else
        begin
            eff_h = frame_height_reg;
        end
        eff_wm1 = eff_w - bb3_pkg::width_t'(1);
        eff_hm1 = eff_h - bb3_pkg::height_t'(1);
    end

    // Pipeline handshake
    logic in_acc;
    logic is_flush;
    logic enter;
    logic s1_v_reg;
    logic s2_v_reg;
    logic s3_v_reg;
    logic s1_free;
    logic s2_free;
    logic s3_free;
    logic adv1;
    logic adv2;
    logic adv3;
    logic s3_hasres;
    logic out_v_reg;
    logic out_phase_reg;
    logic out_two_reg;
    logic out_take;
    logic out_done;
    logic out_free;
    logic load_out;

    bb3_pkg::result_meta_t s3_meta_reg;

    assign in_acc    = pixel_valid && !pixel_stall;
    assign is_flush  = (action == bb3_pkg::ACT_FLUSH);
    assign s3_hasres = s3_meta_reg.has0 || s3_meta_reg.has1;

    assign out_take = out_v_reg && !result_stall;
    assign out_done = out_take && (!out_two_reg || out_phase_reg);
    assign out_free = !out_v_reg || out_done;

    assign adv3     = s3_v_reg && (!s3_hasres || out_free);
    assign load_out = adv3 && s3_hasres;
    assign s3_free  = !s3_v_reg || adv3;
    assign adv2     = s2_v_reg && s3_free;
    assign s2_free  = !s2_v_reg || adv2;
    assign adv1     = s1_v_reg && s2_free;
    assign s1_free  = !s1_v_reg || adv1;

    assign pixel_stall = !s1_free;

    // Frame position
    bb3_pkg::col_t column_count_reg;
    bb3_pkg::col_t column_count_next;
    bb3_pkg::row_t row_count_reg;
    bb3_pkg::row_t row_count_next;
    bb3_pkg::col_t flush_count_reg;
    bb3_pkg::col_t flush_count_next;
    logic          draining_reg;
    logic          draining_next;

    bb3_pkg::col_t   px_x;
    bb3_pkg::row_t   px_y;
    logic            lastcol;
    logic            row_end;
    logic            flush_end;
    bb3_pkg::width_t fk;

    // A flush word is a no-op unless a frame has just been completed.
    assign enter = !is_flush || draining_reg;

    always_comb
    begin
        px_x      = draining_reg ? '0 : column_count_reg;
        px_y      = draining_reg ? '0 : row_count_reg;
        lastcol   = bb3_pkg::width_t'(px_x) >= eff_wm1;
        row_end   = bb3_pkg::height_t'(px_y) >= eff_hm1;
        fk        = bb3_pkg::width_t'(flush_count_reg);
        flush_end = fk >= eff_wm1;
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        flush_count_next  = flush_count_reg;
        draining_next     = draining_reg;
        if (in_acc)
        begin
            if (is_flush)
            begin
                if (draining_reg)
                begin
                    if (flush_end)
                    begin
                        draining_next     = 1'b0;
                        row_count_next    = '0;
                        column_count_next = '0;
                        flush_count_next  = '0;
                    end
                    else
                    begin
                        flush_count_next = flush_count_reg + bb3_pkg::col_t'(1);
                    end
                end
            end
            else
            begin
                draining_next    = 1'b0;
                flush_count_next = '0;
                if (lastcol)
                begin
                    column_count_next = '0;
                    if (row_end)
                    begin
                        draining_next  = 1'b1;
                        row_count_next = px_y;
                    end
                    else
                    begin
                        row_count_next = px_y + bb3_pkg::row_t'(1);
                    end
                end
                else
                begin
                    column_count_next = px_x + bb3_pkg::col_t'(1);
                    row_count_next    = px_y;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            flush_count_reg  <= '0;
            draining_reg     <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            flush_count_reg  <= flush_count_next;
            draining_reg     <= draining_next;
        end
    end

    // Fetch stage: the line store read is issued as the word is accepted.
    bb3_pkg::fetch_t     fetch_next;
    bb3_pkg::fetch_t     s1_reg;
    logic                ram_re;
    bb3_pkg::col_t       ram_raddr;
    logic                ram_we;
    bb3_pkg::col_t       ram_waddr;
    bb3_pkg::line_pair_t ram_wdata;
    bb3_pkg::line_pair_t ram_rdata;

    always_comb
    begin
        fetch_next = '0;
        if (is_flush)
        begin
            fetch_next.flush          = 1'b1;
            fetch_next.first          = (flush_count_reg == '0);
            fetch_next.mask1          = 1'b1;
            fetch_next.mask2          = 1'b1;
            fetch_next.addr           = flush_count_reg;
            fetch_next.info.okl       = fk <= eff_w;
            fetch_next.info.okm       = fk < eff_w;
            fetch_next.info.okr       = (fk + bb3_pkg::width_t'(1)) < eff_w;
            fetch_next.info.meta.has0 = 1'b1;
            fetch_next.info.meta.x0   = flush_count_reg;
            fetch_next.info.meta.x1   = flush_count_reg;
            fetch_next.info.meta.y    = row_count_reg;
            fetch_next.info.meta.last0 = 1'b1;
            fetch_next.info.meta.eof  = flush_end;
        end
        else
        begin
            fetch_next.clr            = (px_x == '0);
            fetch_next.mask1          = (px_y != '0);
            fetch_next.mask2          = (px_y >= bb3_pkg::row_t'(2));
            fetch_next.addr           = px_x;
            fetch_next.rgb            = pixel_word[31:8];
            fetch_next.info.okl       = 1'b1;
            fetch_next.info.okm       = 1'b1;
            fetch_next.info.okr       = 1'b1;
            fetch_next.info.meta.has0 = (px_y != '0) && (px_x != '0);
            fetch_next.info.meta.has1 = (px_y != '0) && lastcol;
            fetch_next.info.meta.x0   = px_x - bb3_pkg::col_t'(1);
            fetch_next.info.meta.x1   = px_x;
            fetch_next.info.meta.y    = px_y - bb3_pkg::row_t'(1);
            fetch_next.info.meta.last0 = !lastcol;
        end
    end

    assign ram_re    = in_acc && enter;
    assign ram_raddr = is_flush ? (flush_count_reg + bb3_pkg::col_t'(1)) : px_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_v_reg <= in_acc && enter;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && enter)
        begin
            s1_reg <= fetch_next;
        end
    end

    // Line stores: the older row takes the newer one, the newer row takes the pixel.
    assign ram_we          = adv1 && !s1_reg.flush;
    assign ram_waddr       = s1_reg.addr;
    assign ram_wdata.older = ram_rdata.newer;
    assign ram_wdata.newer = s1_reg.rgb;

    bb3_ram #(
        .WIDTH (bb3_pkg::LINE_PAIR_W),
        .DEPTH (bb3_pkg::LINE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Copy of column zero, so that the first flush word sees two columns at once.
    bb3_pkg::line_pair_t shadow_reg;

    always_ff @(posedge clk)
    begin
        if (ram_we && (ram_waddr == '0))
        begin
            shadow_reg <= ram_wdata;
        end
    end

    // Window chain: cell 2 takes the new column, the others take their right neighbour.
    bb3_pkg::column_t   new_col;
    bb3_pkg::column_t   shadow_col;
    bb3_pkg::column_t   cell_q   [3];
    bb3_pkg::column_t   cell_din [3];
    bb3_pkg::colsum_t   cell_sum [3];
    bb3_pkg::cell_ctl_t cell_ctl [3];

    always_comb
    begin
        new_col.top    = s1_reg.mask2 ? ram_rdata.older : '0;
        new_col.mid    = s1_reg.mask1 ? ram_rdata.newer : '0;
        new_col.bot    = s1_reg.rgb;
        shadow_col.top = shadow_reg.older;
        shadow_col.mid = shadow_reg.newer;
        shadow_col.bot = '0;

        cell_din[2] = new_col;
        cell_din[1] = s1_reg.first ? shadow_col : cell_q[2];
        cell_din[0] = cell_q[1];

        cell_ctl[2].shift = adv1;
        cell_ctl[2].clr   = 1'b0;
        cell_ctl[1].shift = adv1;
        cell_ctl[1].clr   = s1_reg.clr;
        cell_ctl[0].shift = adv1;
        cell_ctl[0].clr   = s1_reg.clr || s1_reg.first;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_cell
        bb3_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (cell_ctl[i]),
            .din    (cell_din[i]),
            .q      (cell_q[i]),
            .colsum (cell_sum[i])
        );
    end

    // Window stage: the cells hold the window of the word in this stage.
    bb3_pkg::win_info_t s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_v_reg <= adv1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_reg <= s1_reg.info;
        end
    end

    bb3_pkg::colsum_t csl;
    bb3_pkg::colsum_t csm;
    bb3_pkg::colsum_t csr;
    bb3_pkg::winsum_t full_sum;
    bb3_pkg::winsum_t part_sum;

    // Columns outside the frame count as zero during the final row.
    always_comb
    begin
        csl = s2_reg.okl ? cell_sum[0] : '0;
        csm = s2_reg.okm ? cell_sum[1] : '0;
        csr = s2_reg.okr ? cell_sum[2] : '0;
        full_sum.r = bb3_pkg::winval_t'(csl.r) + bb3_pkg::winval_t'(csm.r)
                   + bb3_pkg::winval_t'(csr.r);
        full_sum.g = bb3_pkg::winval_t'(csl.g) + bb3_pkg::winval_t'(csm.g)
                   + bb3_pkg::winval_t'(csr.g);
        full_sum.b = bb3_pkg::winval_t'(csl.b) + bb3_pkg::winval_t'(csm.b)
                   + bb3_pkg::winval_t'(csr.b);
        part_sum.r = bb3_pkg::winval_t'(cell_sum[1].r) + bb3_pkg::winval_t'(cell_sum[2].r);
        part_sum.g = bb3_pkg::winval_t'(cell_sum[1].g) + bb3_pkg::winval_t'(cell_sum[2].g);
        part_sum.b = bb3_pkg::winval_t'(cell_sum[1].b) + bb3_pkg::winval_t'(cell_sum[2].b);
    end

    // Sum stage
    bb3_pkg::winsum_t s3_full_reg;
    bb3_pkg::winsum_t s3_part_reg;
    bb3_pkg::rgb_t    q_full;
    bb3_pkg::rgb_t    q_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            s3_v_reg <= adv2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s3_meta_reg <= s2_reg.meta;
            s3_full_reg <= full_sum;
            s3_part_reg <= part_sum;
        end
    end

    bb3_div9 u_div_full (
        .sum  (s3_full_reg),
        .quot (q_full)
    );

    bb3_div9 u_div_part (
        .sum  (s3_part_reg),
        .quot (q_part)
    );

    // Output register: a word with two results shows them in turn.
    bb3_pkg::rgb_t out_pix0_reg;
    bb3_pkg::rgb_t out_pix1_reg;
    bb3_pkg::col_t out_x0_reg;
    bb3_pkg::col_t out_x1_reg;
    bb3_pkg::row_t out_y_reg;
    logic          out_last0_reg;
    logic          out_eof0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg     <= 1'b0;
            out_phase_reg <= 1'b0;
            out_two_reg   <= 1'b0;
        end
        else if (load_out)
        begin
            out_v_reg     <= 1'b1;
            out_phase_reg <= 1'b0;
            out_two_reg   <= s3_meta_reg.has0 && s3_meta_reg.has1;
        end
        else if (out_done)
        begin
            out_v_reg     <= 1'b0;
            out_phase_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_y_reg    <= s3_meta_reg.y;
            out_pix1_reg <= q_part;
            out_x1_reg   <= s3_meta_reg.x1;
            if (s3_meta_reg.has0)
            begin
                out_pix0_reg  <= q_full;
                out_x0_reg    <= s3_meta_reg.x0;
                out_last0_reg <= s3_meta_reg.last0;
                out_eof0_reg  <= s3_meta_reg.eof;
            end
            else
            begin
                out_pix0_reg  <= q_part;
                out_x0_reg    <= s3_meta_reg.x1;
                out_last0_reg <= 1'b1;
                out_eof0_reg  <= 1'b0;
            end
        end
    end

    assign result_valid = out_v_reg;
    assign out_pixel    = out_phase_reg ? {out_pix1_reg, bb3_pkg::ALPHA_OPAQUE}
                                        : {out_pix0_reg, bb3_pkg::ALPHA_OPAQUE};
    assign out_x        = out_phase_reg ? out_x1_reg : out_x0_reg;
    assign out_y        = out_y_reg;
    assign out_last     = out_phase_reg || out_last0_reg;
    assign end_of_frame = !out_phase_reg && out_eof0_reg;

    // A flush word outside the drain phase must leave the pipeline untouched.
    `BB3_ASSERT_NEXT(a_idle_flush_dropped, in_acc && is_flush && !draining_reg, !s1_v_reg)
    // The drain phase only starts at the end of a line.
    `BB3_ASSERT_IMPLIES(a_drain_at_line_start, draining_reg, column_count_reg == '0)
    // The line store never reads the entry it is writing in the same cycle.
    `BB3_ASSERT_IMPLIES(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Box blur unit testbench
// Streams directed and random RGBA words through the 3x3 box blur unit,
// predicts every blurred word from its own copy of the line stores and
// window, and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bb3_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 800_000;
    localparam int unsigned RANDOM_WORDS = 1300;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned QUIET_FROM   = 700;
    localparam int unsigned QUIET_TO     = 1500;
    localparam int unsigned IDLE_PERCENT = 31;

    typedef struct packed {
        logic        act;
        logic [31:0] word;
    } in_word_t;

    typedef struct packed {
        logic [31:0] pix;
        col_t        x;
        row_t        y;
        logic        last;
        logic        eof;
    } blur_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    cfg_index_t            cfg_index    = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_stall;
    logic                  action       = ACT_PIXEL;
    logic [31:0]           pixel_word   = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [31:0]           out_pixel;
    col_t                  out_x;
    row_t                  out_y;
    logic                  out_last;
    logic                  end_of_frame;

    in_word_t    word_queue[$];
    blur_t       blurred_due[$];
    in_word_t    next_word;
    blur_t       due;
    int unsigned cycle_count = 0;
    int          error_count = 0;

    // Predicted state of the filter, starting at its reset values.
    width_t      width_copy  = WIDTH_RESET;
    height_t     height_copy = HEIGHT_RESET;
    rgb_t        older_line [LINE_DEPTH];
    rgb_t        newer_line [LINE_DEPTH];
    rgb_t        win_cells [3][3] = '{default: '0};
    int unsigned col_pos   = 0;
    int unsigned row_pos   = 0;
    int unsigned flush_pos = 0;
    bit          draining  = 1'b0;

    box_blur_3x3_rgb_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .action       (action),
        .pixel_word   (pixel_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_pixel    (out_pixel),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_last     (out_last),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_copy;
        if (w < WIDTH_MIN) w = WIDTH_MIN;
        if (w > WIDTH_MAX) w = WIDTH_MAX;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = height_copy;
        if (h < HEIGHT_MIN) h = HEIGHT_MIN;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        return h;
    endfunction

    function automatic logic [31:0] blur_pack(int unsigned sr, int unsigned sg, int unsigned sb);
        return {CHAN_W'(sr / 9), CHAN_W'(sg / 9), CHAN_W'(sb / 9), ALPHA_OPAQUE};
    endfunction

    function automatic void due_result(logic [31:0] pix, int unsigned x, int unsigned y,
                                       logic last, logic eof);
        blurred_due.push_back(blur_t'{pix, col_t'(x), row_t'(y), last, eof});
    endfunction

    // Sums the window from the given column rightwards; the right-hand edge
    // output leaves out the oldest column.
    function automatic logic [31:0] window_blur(int unsigned first_col);
        int unsigned sr, sg, sb, r, c;
        sr = 0;
        sg = 0;
        sb = 0;
        for (r = 0; r < 3; r++)
            for (c = first_col; c < 3; c++)
            begin
                sr += win_cells[r][c].r;
                sg += win_cells[r][c].g;
                sb += win_cells[r][c].b;
            end
        return blur_pack(sr, sg, sb);
    endfunction

    function automatic void blur_word(logic act, logic [31:0] word);
        int unsigned w, h, x, y, k, c, sr, sg, sb;
        logic        lastcol;
        w = eff_width();
        h = eff_height();
        if (act == ACT_FLUSH)
        begin
            // A flush word outside the drain phase is ignored.
            if (!draining) return;
            k  = flush_pos;
            sr = 0;
            sg = 0;
            sb = 0;
            for (c = (k == 0) ? 0 : k - 1; c <= k + 1; c++)
                if (c < w)
                begin
                    sr += older_line[c].r + newer_line[c].r;
                    sg += older_line[c].g + newer_line[c].g;
                    sb += older_line[c].b + newer_line[c].b;
                end
            due_result(blur_pack(sr, sg, sb), k, row_pos, 1'b1, k >= w - 1);
            if (k >= w - 1)
            begin
                draining  = 1'b0;
                row_pos   = 0;
                col_pos   = 0;
                flush_pos = 0;
            end
            else
                flush_pos = k + 1;
        end
        else
        begin
            // A pixel during the drain phase starts a fresh frame.
            if (draining)
            begin
                draining  = 1'b0;
                row_pos   = 0;
                col_pos   = 0;
                flush_pos = 0;
            end
            x = col_pos;
            y = row_pos;
            if (x >= LINE_DEPTH) x = LINE_DEPTH - 1;
            if (x == 0) win_cells = '{default: '0};
            for (c = 0; c < 3; c++)
            begin
                win_cells[c][0] = win_cells[c][1];
                win_cells[c][1] = win_cells[c][2];
            end
            win_cells[0][2] = (y >= 2) ? older_line[x] : '0;
            win_cells[1][2] = (y >= 1) ? newer_line[x] : '0;
            win_cells[2][2] = word[31:8];
            older_line[x]   = newer_line[x];
            newer_line[x]   = word[31:8];
            lastcol = (x >= w - 1);
            if (y >= 1 && x >= 1) due_result(window_blur(0), x - 1, y - 1, !lastcol, 1'b0);
            if (y >= 1 && lastcol) due_result(window_blur(1), x, y - 1, 1'b1, 1'b0);
            if (lastcol)
            begin
                col_pos = 0;
                if (y >= h - 1)
                begin
                    draining  = 1'b1;
                    flush_pos = 0;
                end
                else
                    row_pos = y + 1;
            end
            else
                col_pos = x + 1;
        end
    endfunction

    function automatic bit idle_draw();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    function automatic logic [31:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 32'hFFFF_FFFF;
        if (r < 12) return 32'h0000_0000;
        return $urandom;
    endfunction

    // The prediction runs as each word is taken, so it sees the exact stream.
    always @(posedge clk)
    begin
        if (!rst_n)
            pixel_valid <= 1'b0;
        else
        begin
            if (pixel_valid && !pixel_stall)
                blur_word(action, pixel_word);
            if (!pixel_valid || !pixel_stall)
            begin
                if (word_queue.size() != 0 && !idle_draw())
                begin
                    next_word = word_queue.pop_front();
                    action      <= next_word.act;
                    pixel_word  <= next_word.word;
                    pixel_valid <= 1'b1;
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        result_stall <= idle_draw();

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (blurred_due.size() == 0)
            begin
                $error("unexpected result word: x %0d y %0d", out_x, out_y);
                error_count++;
            end
            else
            begin
                due = blurred_due.pop_front();
                if (out_pixel !== due.pix)
                begin
                    $error("out_pixel: expected %h, got %h", due.pix, out_pixel);
                    error_count++;
                end
                if (out_x !== due.x)
                begin
                    $error("out_x: expected %0d, got %0d", due.x, out_x);
                    error_count++;
                end
                if (out_y !== due.y)
                begin
                    $error("out_y: expected %0d, got %0d", due.y, out_y);
                    error_count++;
                end
                if (out_last !== due.last)
                begin
                    $error("out_last: expected %b, got %b", due.last, out_last);
                    error_count++;
                end
                if (end_of_frame !== due.eof)
                begin
                    $error("end_of_frame: expected %b, got %b", due.eof, end_of_frame);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_pixel(logic [31:0] word);
        word_queue.push_back(in_word_t'{ACT_PIXEL, word});
    endtask

    task automatic queue_flush();
        word_queue.push_back(in_word_t'{ACT_FLUSH, $urandom});
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_copy = width_t'(value);
        else
            height_copy = height_t'(value);
    endtask

    // Holds the sender off until every word has gone and every result has
    // come, then lets the pipeline empty of words that cause no result.
    task automatic wait_idle();
        @(negedge clk);
        while (word_queue.size() != 0 || pixel_valid || blurred_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int unsigned wv, hv, w, h, r, n_pix, n_flush, total, cut, i, extra;
        int unsigned random_words;
        bit          clean;
        random_words = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Part of row 0 at the reset size, then a flush that no frame precedes.
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFF00_FF00);
        queue_pixel(32'h00FF_00FF);
        queue_flush();
        wait_idle();

        // Shrinking the width leaves the column counter past the new last column.
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        @(negedge clk);
        queue_pixel(32'h1234_5678);
        repeat (3) queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        repeat (3) queue_flush();
        // Alpha-only words alternate with white ones; a pixel then cuts the drain short.
        for (i = 0; i < 9; i++)
            queue_pixel(i[0] ? 32'h0000_00FF : 32'hFFFF_FF00);
        queue_flush();
        queue_pixel(32'hFFFF_FFFF);
        wait_idle();

        while (random_words < RANDOM_WORDS)
        begin
            w     = eff_width();
            clean = !draining && row_pos == 0 && col_pos == 0;
            r = $urandom_range(99);
            if (r < 10)
                wv = $urandom_range(2, 0);
            else if (r < 80)
                wv = $urandom_range(8, 3);
            else
                wv = $urandom_range(24, 9);
            // Mid-frame the line stores hold only the current width.
            if (!clean && wv > w) wv = $urandom_range(w, 0);
            r = $urandom_range(99);
            if (r < 10)
                hv = $urandom_range(2, 0);
            else if (r < 85)
                hv = $urandom_range(6, 3);
            else
                hv = $urandom_range(12, 7);
            write_reg(REG_FRAME_WIDTH, wv);
            write_reg(REG_FRAME_HEIGHT, hv);
            @(negedge clk);

            // Carry on from wherever the frame stands to the end of its drain.
            w = eff_width();
            h = eff_height();
            if (draining)
            begin
                n_pix   = 0;
                n_flush = (flush_pos >= w - 1) ? 1 : w - flush_pos;
            end
            else
            begin
                n_pix = (col_pos >= w - 1) ? 1 : w - col_pos;
                if (row_pos < h - 1) n_pix += (h - 1 - row_pos) * w;
                n_flush = w;
            end
            total = n_pix + n_flush;
            cut   = total;
            if ($urandom_range(99) < 25) cut = $urandom_range(total, 1);
            for (i = 0; i < cut; i++)
            begin
                if (i < n_pix)
                begin
                    if ($urandom_range(99) < 3) queue_flush();
                    queue_pixel(pick_pixel());
                end
                else
                    queue_flush();
            end
            if (cut < total && cut >= n_pix && $urandom_range(1) == 1)
            begin
                extra = $urandom_range(3, 1);
                for (i = 0; i < extra; i++)
                    queue_pixel(pick_pixel());
                random_words += extra;
            end
            random_words += cut;
            wait_idle();
        end

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
